### sv/cpa_pkg.sv
// shared types, codes and sizes of the cell pool allocator
`timescale 1ns / 1ps
package cpa_pkg;

   localparam int MAX_CELLS  = 256;
   localparam int CELL_W     = $clog2(MAX_CELLS);
   localparam int LINK_W     = CELL_W + 1;
   localparam int COUNT_W    = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LINK_W-1:0]  NONE_LINK     = LINK_W'(MAX_CELLS);
   localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(256);
   localparam logic [COUNT_W-1:0] MAX_CELLS_CNT = COUNT_W'(MAX_CELLS);

   // action codes
   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_RELEASE = 3'd1;
   localparam logic [2:0] ACT_FIRST   = 3'd2;
   localparam logic [2:0] ACT_NEXT    = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   // register index
   localparam logic [CSR_ADDR_W-3:0] REG_CELL_COUNT = '0;

   typedef struct packed {
      logic [2:0]        action;
      logic [CELL_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] result_cell;
      logic              has_cell;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [LINK_W-1:0] wdata;
      logic              re;
      logic [CELL_W-1:0] raddr;
   } link_port_type;

endpackage

### sv/cpa_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
module cpa_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 9
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/cpa_csr.sv
// configuration register block with its apb-style access port
`timescale 1ns / 1ps
module cpa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cpa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cpa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [cpa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [cpa_pkg::COUNT_W-1:0]      cell_count
);
   import cpa_pkg::*;

   logic [COUNT_W-1:0] cell_count_ff, cell_count_in;
   logic               sel_count;

   assign sel_count = (paddr[CSR_ADDR_W-1:2] == REG_CELL_COUNT);

   always_comb begin
      cell_count_in = cell_count_ff;
      if (psel && penable && pwrite && sel_count) begin
         cell_count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= COUNT_RESET;
      end else begin
         cell_count_ff <= cell_count_in;
      end
   end

   assign prdata     = sel_count ? CSR_DATA_W'(cell_count_ff) : '0;
   assign pready     = 1'b1;
   assign cell_count = cell_count_ff;

endmodule

### sv/cpa_ctrl.sv
// list sequencer: heads, fresh mark, in-use bits and link memory accesses
`timescale 1ns / 1ps
module cpa_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  cpa_pkg::req_type               req_data,
   output logic                           busy,
   output logic                           rsp_strobe,
   output cpa_pkg::rsp_type               rsp_data,
   input  logic [cpa_pkg::COUNT_W-1:0]    cell_count,
   output cpa_pkg::link_port_type         next_port,
   input  logic [cpa_pkg::LINK_W-1:0]     next_rdata,
   output cpa_pkg::link_port_type         prev_port,
   input  logic [cpa_pkg::LINK_W-1:0]     prev_rdata
);
   import cpa_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_ALLOC_A = 6'b000010,
      ST_ALLOC_B = 6'b000100,
      ST_REL_A   = 6'b001000,
      ST_REL_B   = 6'b010000,
      ST_NEXT    = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [LINK_W-1:0]    free_head_ff, free_head_in;
   logic [LINK_W-1:0]    used_head_ff, used_head_in;
   logic [LINK_W-1:0]    fresh_ff, fresh_in;
   logic [MAX_CELLS-1:0] in_use_ff, in_use_in;
   logic [CELL_W-1:0]    cell_ff, cell_in;
   logic                 from_free_ff, from_free_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [COUNT_W-1:0]   live_count;
   logic                 accept;
   logic                 cell_ok;
   logic                 head_hit;

   assign live_count = (cell_count > MAX_CELLS_CNT) ? MAX_CELLS_CNT : cell_count;
   assign accept     = start && (state_ff == ST_IDLE);
   assign cell_ok    = (COUNT_W'(req_data.cell_index) < live_count)
                       && in_use_ff[req_data.cell_index];
   assign head_hit   = (used_head_ff == LINK_W'(cell_ff));

   always_comb begin
      state_in     = state_ff;
      free_head_in = free_head_ff;
      used_head_in = used_head_ff;
      fresh_in     = fresh_ff;
      in_use_in    = in_use_ff;
      cell_in      = cell_ff;
      from_free_in = from_free_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      next_port    = '0;
      prev_port    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_ALLOC: begin
                     if (free_head_ff < NONE_LINK) begin
                        cell_in         = free_head_ff[CELL_W-1:0];
                        from_free_in    = 1'b1;
                        next_port.re    = 1'b1;
                        next_port.raddr = free_head_ff[CELL_W-1:0];
                        state_in        = ST_ALLOC_A;
                     end else if (COUNT_W'(fresh_ff) < live_count) begin
                        cell_in      = fresh_ff[CELL_W-1:0];
                        from_free_in = 1'b0;
                        fresh_in     = fresh_ff + LINK_W'(1);
                        state_in     = ST_ALLOC_A;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{result_cell: '0, has_cell: 1'b0,
                                         status: STATUS_EXHAUSTED};
                     end
                  end
                  ACT_RELEASE: begin
                     if (cell_ok) begin
                        cell_in         = req_data.cell_index;
                        next_port.re    = 1'b1;
                        next_port.raddr = req_data.cell_index;
                        prev_port.re    = 1'b1;
                        prev_port.raddr = req_data.cell_index;
                        state_in        = ST_REL_A;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{result_cell: '0, has_cell: 1'b0,
                                         status: STATUS_RANGE};
                     end
                  end
                  ACT_FIRST: begin
                     rsp_valid_in = 1'b1;
                     if (used_head_ff < NONE_LINK) begin
                        rsp_in = '{result_cell: used_head_ff[CELL_W-1:0], has_cell: 1'b1,
                                   status: STATUS_OK};
                     end else begin
                        rsp_in = '{result_cell: '0, has_cell: 1'b0, status: STATUS_OK};
                     end
                  end
                  ACT_NEXT: begin
                     if (cell_ok) begin
                        next_port.re    = 1'b1;
                        next_port.raddr = req_data.cell_index;
                        state_in        = ST_NEXT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{result_cell: '0, has_cell: 1'b0,
                                         status: STATUS_RANGE};
                     end
                  end
                  ACT_CLEAR: begin
                     in_use_in    = '0;
                     free_head_in = NONE_LINK;
                     used_head_in = NONE_LINK;
                     fresh_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_cell: '0, has_cell: 1'b0, status: STATUS_OK};
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_cell: '0, has_cell: 1'b0, status: STATUS_OK};
                  end
               endcase
            end
         end
         ST_ALLOC_A: begin
            // pop the free list and link the new cell ahead of the old head
            if (from_free_ff) begin
               free_head_in = next_rdata;
            end
            next_port.we    = 1'b1;
            next_port.waddr = cell_ff;
            next_port.wdata = used_head_ff;
            if (used_head_ff < NONE_LINK) begin
               prev_port.we    = 1'b1;
               prev_port.waddr = used_head_ff[CELL_W-1:0];
               prev_port.wdata = LINK_W'(cell_ff);
            end
            state_in = ST_ALLOC_B;
         end
         ST_ALLOC_B: begin
            prev_port.we      = 1'b1;
            prev_port.waddr   = cell_ff;
            prev_port.wdata   = NONE_LINK;
            used_head_in      = LINK_W'(cell_ff);
            in_use_in[cell_ff] = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_in            = '{result_cell: cell_ff, has_cell: 1'b1, status: STATUS_OK};
            state_in          = ST_IDLE;
         end
         ST_REL_A: begin
            // unlink: next_rdata and prev_rdata hold the cell's neighbors
            if (head_hit) begin
               used_head_in = next_rdata;
            end else if (prev_rdata < NONE_LINK) begin
               next_port.we    = 1'b1;
               next_port.waddr = prev_rdata[CELL_W-1:0];
               next_port.wdata = next_rdata;
            end
            if (next_rdata < NONE_LINK) begin
               prev_port.we    = 1'b1;
               prev_port.waddr = next_rdata[CELL_W-1:0];
               prev_port.wdata = (head_hit || (used_head_ff == next_rdata)) ?
                                 NONE_LINK : prev_rdata;
            end
            state_in = ST_REL_B;
         end
         ST_REL_B: begin
            next_port.we       = 1'b1;
            next_port.waddr    = cell_ff;
            next_port.wdata    = free_head_ff;
            free_head_in       = LINK_W'(cell_ff);
            in_use_in[cell_ff] = 1'b0;
            rsp_valid_in       = 1'b1;
            rsp_in             = '{result_cell: '0, has_cell: 1'b0, status: STATUS_OK};
            state_in           = ST_IDLE;
         end
         ST_NEXT: begin
            rsp_valid_in = 1'b1;
            if (next_rdata < NONE_LINK) begin
               rsp_in = '{result_cell: next_rdata[CELL_W-1:0], has_cell: 1'b1,
                          status: STATUS_OK};
            end else begin
               rsp_in = '{result_cell: '0, has_cell: 1'b0, status: STATUS_OK};
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= NONE_LINK;
         used_head_ff <= NONE_LINK;
         fresh_ff     <= '0;
         in_use_ff    <= '0;
         from_free_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         fresh_ff     <= fresh_in;
         in_use_ff    <= in_use_in;
         from_free_ff <= from_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

### sv/cell_pool_allocator_top.sv
// cell pool allocator: free list and in-use list of pool cells kept by index
//
// usage: drive req_data and raise start; the beat is taken at a rising edge
// with start high and busy low. each beat gives exactly one result, shown on
// rsp_data for one cycle with rsp_strobe high; the receiver cannot stall it.
// what each beat does, from acceptance to the next acceptance:
//   allocate and release: one link read (none when allocate takes a fresh
//   cell), then two link writes, as each link memory has one write port
//   next: one link read
//   first, clear, exhausted or rejected beats: no link memory access
// the result strobe shows in the cycle in which the block is idle again, so the
// result and the next beat can be taken at the same edge.
// the links sit in two 256-entry memories (next and prev) with registered read
// data; heads, fresh mark and per-cell in-use bits are flip-flops.
// reset empties both lists at once and sets cell_count to 256; no clearing
// pass is needed. the user must write cell_count through the apb-style port
// at byte address 0 only while the block is idle; the block does not check it.
`timescale 1ns / 1ps
module cell_pool_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  cpa_pkg::req_type               req_data,
   output logic                           busy,
   output logic                           rsp_strobe,
   output cpa_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cpa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cpa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cpa_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import cpa_pkg::*;

   logic [COUNT_W-1:0] cell_count;
   link_port_type      next_port;
   link_port_type      prev_port;
   logic [LINK_W-1:0]  next_rdata;
   logic [LINK_W-1:0]  prev_rdata;

   cpa_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cell_count (cell_count)
   );

   cpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .cell_count (cell_count),
      .next_port  (next_port),
      .next_rdata (next_rdata),
      .prev_port  (prev_port),
      .prev_rdata (prev_rdata)
   );

   cpa_ram #(
      .ADDR_W (CELL_W),
      .DATA_W (LINK_W)
   ) u_next_ram (
      .clock (clock),
      .we    (next_port.we),
      .waddr (next_port.waddr),
      .wdata (next_port.wdata),
      .re    (next_port.re),
      .raddr (next_port.raddr),
      .rdata (next_rdata)
   );

   cpa_ram #(
      .ADDR_W (CELL_W),
      .DATA_W (LINK_W)
   ) u_prev_ram (
      .clock (clock),
      .we    (prev_port.we),
      .waddr (prev_port.waddr),
      .wdata (prev_port.wdata),
      .re    (prev_port.re),
      .raddr (prev_port.raddr),
      .rdata (prev_rdata)
   );

endmodule
